@@ hw/rtl/lfo_pkg.sv @@
// shared constants, codes and the quarter-wave cosine function of the lfo
package lfo_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT = 2'd2;

    // wave shape codes
    localparam int WAVE_W = 3;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW_DOWN = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAW_UP   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_HOLD     = 3'd5;

    // field widths
    localparam int PHASE_W  = 32;
    localparam int AMP_W    = 16;
    localparam int NOISE_W  = 8;
    localparam int SAMPLE_W = 26;
    localparam int COS_W    = 25;
    localparam int LEVEL_W  = 29;

    // q2.24 unity and a quarter turn of phase
    localparam logic signed [SAMPLE_W-1:0] ONE_Q24 = 26'sh100_0000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN    = 32'h4000_0000;

    // noise generator
    localparam logic [15:0] NOISE_MUL = 16'd179;
    localparam logic [15:0] NOISE_ADD = 16'd17;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // quarter-wave cosine in q24, entry r of a quadrant of 2^qbits steps
    function automatic logic [COS_W-1:0] quarter_cos(input int unsigned r,
                                                     input int unsigned qbits);
        longint theta;
        longint t2;
        longint u;
        longint sh;
        longint d;
        theta = (longint'(r) * HALF_PI_Q30) >>> qbits;
        t2    = (theta * theta) >>> 30;
        u     = ONE_Q30;
        for (int i = 0; i < 6; i++) begin
            sh = (t2 * u) >>> 30;
            case (i)
                0:       d = sh / 132;
                1:       d = sh / 90;
                2:       d = sh / 56;
                3:       d = sh / 30;
                4:       d = sh / 12;
                default: d = sh / 2;
            endcase
            u = ONE_Q30 - d;
        end
        if (u < 0) u = 0;
        if (u > ONE_Q30) u = ONE_Q30;
        return COS_W'((u + 32) >>> 6);
    endfunction

endpackage

@@ hw/rtl/lfo_if.sv @@
// channel interfaces of the lfo: tick input, level output, configuration writes
interface lfo_tick_if;
    logic valid;
    logic ready;
    logic sync;
    modport source (output valid, output sync, input ready);
    modport sink   (input valid, input sync, output ready);
endinterface

interface lfo_level_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lfo_pkg::LEVEL_W-1:0]     level;
    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface lfo_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lfo_pkg::CFG_INDEX_W-1:0]    index;
    logic [lfo_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/lfo_waveform_generator.sv @@
// top level of the low-frequency oscillator with phase accumulator and six shapes
//
// channels: i_tick carries one transaction per output sample, its sync bit clears the
// phase before that tick's advance; o_level returns one signed q5.24 level per tick;
// i_cfg writes phase_step (index 0), amplitude (1) and wave_select (2), always ready,
// and is meant to be written only while no tick is in flight.
// pipeline: accept stage updates phase and noise state, shape stage forms the sample
// and reads the cosine rom, output stage multiplies by amplitude and saturates.
// path: a tick taken into the accept stage passes the shape register, then the output
// register, before it shows on o_level. throughput: one tick per cycle while o_level
// is not stalled, set by the three-register pipeline with one multiplier in the output stage.
// stall: each stage holds when the one after it is full, so up to two more ticks
// are taken while a level waits; i_tick.ready drops only with all three stages full.
// reset: synchronous active-low i_rst_n clears phase, noise, registers and valids.
module lfo_waveform_generator #(
    parameter int SINE_TABLE_BITS     = 10,
    parameter int AMPLITUDE_FRAC_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lfo_tick_if.sink        i_tick,
    lfo_cfg_if.sink         i_cfg,
    lfo_level_if.source     o_level
);

    localparam int PROD_W = lfo_pkg::SAMPLE_W + lfo_pkg::AMP_W + 1;

    // configuration registers
    logic [lfo_pkg::PHASE_W-1:0]    r_phase_step;
    logic [lfo_pkg::AMP_W-1:0]      r_amplitude;
    logic [lfo_pkg::WAVE_W-1:0]     r_wave_select;

    // oscillator state, also the payload of the accept stage
    logic [lfo_pkg::PHASE_W-1:0]    r_phase;
    logic [lfo_pkg::NOISE_W-1:0]    r_noise;
    logic [lfo_pkg::PHASE_W-1:0]    n_phase;
    logic [lfo_pkg::NOISE_W-1:0]    n_noise;

    // stage valids and the output register
    logic                                   r_s1_valid;
    logic                                   r_s2_valid;
    logic                                   r_out_valid;
    logic signed [lfo_pkg::LEVEL_W-1:0]     r_level;
    logic signed [lfo_pkg::LEVEL_W-1:0]     n_level;

    logic                                   w_en_out;
    logic                                   w_en2;
    logic                                   w_en1;
    logic [lfo_pkg::WAVE_W-1:0]             w_wave_wr;
    logic signed [lfo_pkg::SAMPLE_W-1:0]    w_sample;
    logic signed [PROD_W-1:0]               w_prod;
    logic signed [PROD_W-1:0]               w_scaled;

    // a stage moves on when it is empty or the stage after it moves
    assign w_en_out   = !r_out_valid || o_level.ready;
    assign w_en2      = !r_s2_valid || w_en_out;
    assign w_en1      = !r_s1_valid || w_en2;

    assign i_tick.ready  = w_en1;
    assign i_cfg.ready   = 1'b1;
    assign o_level.valid = r_out_valid;
    assign o_level.level = r_level;

    // unused shape codes fold onto sample-and-hold
    assign w_wave_wr = (i_cfg.data[2:0] > lfo_pkg::WAVE_HOLD) ? lfo_pkg::WAVE_HOLD
                                                               : i_cfg.data[2:0];

    always_comb begin
        n_phase = (i_tick.sync ? '0 : r_phase) + r_phase_step;
        n_noise = r_noise;
        // wrap shows as the new phase landing below the step
        if (r_wave_select == lfo_pkg::WAVE_HOLD && n_phase < r_phase_step) begin
            n_noise = 8'((16'(r_noise) * lfo_pkg::NOISE_MUL) + lfo_pkg::NOISE_ADD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_amplitude   <= '0;
            r_wave_select <= lfo_pkg::WAVE_TRIANGLE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lfo_pkg::REG_PHASE_STEP:  r_phase_step  <= i_cfg.data;
                lfo_pkg::REG_AMPLITUDE:   r_amplitude   <= i_cfg.data[lfo_pkg::AMP_W-1:0];
                lfo_pkg::REG_WAVE_SELECT: r_wave_select <= w_wave_wr;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_noise    <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_tick.valid;
            if (i_tick.valid) begin
                r_phase <= n_phase;
                r_noise <= n_noise;
            end
        end
    end

    lfo_shape #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_shape (
        .i_clk    (i_clk),
        .i_en     (w_en2),
        .i_phase  (r_phase),
        .i_noise  (r_noise),
        .i_sel    (r_wave_select),
        .o_sample (w_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // depth scaling: arithmetic shift floors, then clamp to the level range
    always_comb begin
        w_prod   = w_sample * $signed({1'b0, r_amplitude});
        w_scaled = w_prod >>> AMPLITUDE_FRAC_BITS;
        if (w_scaled[PROD_W-1:lfo_pkg::LEVEL_W-1] == '0 ||
            w_scaled[PROD_W-1:lfo_pkg::LEVEL_W-1] == '1) begin
            n_level = w_scaled[lfo_pkg::LEVEL_W-1:0];
        end else if (w_scaled[PROD_W-1]) begin
            n_level = {1'b1, {(lfo_pkg::LEVEL_W-1){1'b0}}};
        end else begin
            n_level = {1'b0, {(lfo_pkg::LEVEL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_s2_valid) begin
            r_level <= n_level;
        end
    end

endmodule

@@ hw/rtl/lfo_shape.sv @@
// wave shape stage: forms the q2.24 sample from the phase, with the cosine rom
module lfo_shape #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [lfo_pkg::PHASE_W-1:0]             i_phase,
    input  logic [lfo_pkg::NOISE_W-1:0]             i_noise,
    input  logic [lfo_pkg::WAVE_W-1:0]              i_sel,
    output logic signed [lfo_pkg::SAMPLE_W-1:0]     o_sample
);

    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int AW      = SINE_TABLE_BITS - 1;
    localparam int DEPTH   = (1 << QBITS) + 1;
    localparam logic [AW-1:0] C_Q = AW'(1 << QBITS);

    // quarter-wave table, entries 0..Q, folded from constants at elaboration
    logic [lfo_pkg::COS_W-1:0] w_qtab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_qtab
        assign w_qtab[g] = lfo_pkg::quarter_cos(g, QBITS);
    end

    logic [lfo_pkg::PHASE_W-1:0]            w_tri_t;
    logic [24:0]                            w_tri;
    logic [lfo_pkg::PHASE_W-1:0]            w_neg_phase;
    logic [lfo_pkg::PHASE_W-1:0]            w_cos_x;
    logic [SINE_TABLE_BITS-1:0]             w_idx;
    logic [1:0]                             w_quad;
    logic [AW-1:0]                          w_rem;
    logic [AW-1:0]                          w_addr;
    logic signed [lfo_pkg::SAMPLE_W-1:0]    n_sample;

    logic signed [lfo_pkg::SAMPLE_W-1:0]    r_sample;
    logic [lfo_pkg::COS_W-1:0]              r_cos;
    logic                                   r_is_sine;
    logic                                   r_neg;

    always_comb begin
        w_tri_t     = i_phase + lfo_pkg::QUARTER_TURN;
        w_tri       = w_tri_t[31] ? ~w_tri_t[30:6] : w_tri_t[30:6];
        w_neg_phase = '0 - i_phase;
        w_cos_x     = i_phase - lfo_pkg::QUARTER_TURN;
        w_idx       = w_cos_x[31 -: SINE_TABLE_BITS];
        w_quad      = w_idx[SINE_TABLE_BITS-1 -: 2];
        w_rem       = {1'b0, w_idx[QBITS-1:0]};
        // odd quadrants mirror the quarter wave
        w_addr      = w_quad[0] ? (C_Q - w_rem) : w_rem;

        case (i_sel)
            lfo_pkg::WAVE_TRIANGLE: n_sample = $signed({1'b0, w_tri}) - lfo_pkg::ONE_Q24;
            lfo_pkg::WAVE_SAW_DOWN: n_sample = $signed({w_neg_phase[31], w_neg_phase[31:7]});
            lfo_pkg::WAVE_SAW_UP:   n_sample = $signed({i_phase[31], i_phase[31:7]});
            lfo_pkg::WAVE_SQUARE:   n_sample = i_phase[31] ? -lfo_pkg::ONE_Q24
                                                           : lfo_pkg::ONE_Q24;
            lfo_pkg::WAVE_SINE:     n_sample = '0;
            default:                n_sample = $signed({i_noise[7], i_noise, 17'd0});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample  <= n_sample;
            r_cos     <= w_qtab[w_addr];
            r_is_sine <= (i_sel == lfo_pkg::WAVE_SINE);
            r_neg     <= (w_quad == 2'd1) || (w_quad == 2'd2);
        end
    end

    always_comb begin
        if (!r_is_sine) begin
            o_sample = r_sample;
        end else if (r_neg) begin
            o_sample = -$signed({1'b0, r_cos});
        end else begin
            o_sample = $signed({1'b0, r_cos});
        end
    end

endmodule

@@ hw/rtl/lfo_checker.sv @@
// port-level checker of the lfo and its bind to the top level
module lfo_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tick_ready,
    input  logic                                i_cfg_ready,
    input  logic                                i_level_valid,
    input  logic                                i_level_ready,
    input  logic signed [lfo_pkg::LEVEL_W-1:0]  i_level
);

    // a held level stays offered
    a_level_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_level_valid && !i_level_ready |=> i_level_valid)
        else $error("level valid dropped while stalled");

    // a held level keeps its value
    a_level_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_level_valid && !i_level_ready |=> $stable(i_level))
        else $error("level changed while stalled");

    // the tick side only backs up behind a stalled output
    a_tick_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick_ready |-> i_level_valid && !i_level_ready)
        else $error("tick ready low without a stalled level");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration ready low");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_tick_ready  (i_tick.ready),
    .i_cfg_ready   (i_cfg.ready),
    .i_level_valid (o_level.valid),
    .i_level_ready (o_level.ready),
    .i_level       (o_level.level)
);
